FILE: src/rhp_pkg.sv
// ---------------------------------------------------------------------------
// rhp_pkg
// shared constants for the rtp header parser: counter width, header sizes,
// status codes
// ---------------------------------------------------------------------------
`default_nettype none

package rhp_pkg;

  // width of the byte counter, 8 to 16
  localparam int LENGTH_BITS = 16;
  localparam logic [LENGTH_BITS-1:0] COUNT_MAX = {LENGTH_BITS{1'b1}};

  localparam int FIXED_HDR = 12;
  localparam int WORD_BYTES = 4;

  // result fields are 16 bits wide whatever the counter width
  localparam int OUT_LEN_BITS = 16;
  localparam logic [OUT_LEN_BITS-1:0] OUT_LEN_MAX = {OUT_LEN_BITS{1'b1}};

  localparam logic [1:0] HDR_VER_EXPECTED = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SHORT      = 3'd1;
  localparam logic [2:0] ST_BAD_VER    = 3'd2;
  localparam logic [2:0] ST_EXT_OVER   = 3'd3;
  localparam logic [2:0] ST_PAD_OVER   = 3'd4;

endpackage

`default_nettype wire

FILE: src/rtp_header_parser.sv
// ---------------------------------------------------------------------------
// rtp_header_parser
// parses an rtp packet that arrives one byte per item and reports the
// header fields, the payload offset and the payload length once per packet
// ---------------------------------------------------------------------------
// input channel: in_valid / in_ready, with packet_byte and last_byte. bytes
// come in wire order; last_byte marks the final byte of a packet.
// output channel: out_valid / out_ready, one result per packet carrying
// status, the fixed header fields, the extension header and the payload
// offset and length with trailing padding removed.
// throughput: one byte per cycle, sustained while in_ready stays high, also across packet borders.
// result path: when the final byte is taken, the capture registers and the
// byte counter feed a snapshot register, and the length arithmetic between
// the snapshot and the result register loads the result once the result
// register is free.
// reset: rst (synchronous) clears the counter, the captured words and both
// valid flags; the block then waits for the first byte of a packet.
// stall: while out_valid waits for out_ready the snapshot still fills from
// the next final byte; only when both the snapshot and the result register
// are full does in_ready drop.
// ---------------------------------------------------------------------------
`default_nettype none

module rtp_header_parser
  import rhp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [7:0]              packet_byte,
  input  wire logic                    last_byte,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   status,
  output logic                         marker,
  output logic [6:0]                   payload_kind,
  output logic [15:0]                  sequence_res,
  output logic [31:0]                  time_stamp,
  output logic [31:0]                  source_id,
  output logic [3:0]                   contrib_count,
  output logic                         has_extension,
  output logic [15:0]                  ext_profile,
  output logic [15:0]                  ext_words,
  output logic [OUT_LEN_BITS-1:0]      payload_offset,
  output logic [OUT_LEN_BITS-1:0]      payload_length
);

  // capture state
  logic [LENGTH_BITS-1:0] byte_count;
  logic [31:0]            first_word;
  logic [31:0]            stamp_word;
  logic [31:0]            source_word;
  logic [31:0]            ext_header_word;

  logic [LENGTH_BITS-1:0] byte_count_next;
  logic [31:0]            first_word_next;
  logic [31:0]            stamp_word_next;
  logic [31:0]            source_word_next;
  logic [31:0]            ext_header_word_next;
  logic [LENGTH_BITS-1:0] ext_start;
  logic                   in_ext;

  // snapshot of a finished packet
  logic                   snap_valid;
  logic [LENGTH_BITS-1:0] snap_count;
  logic [31:0]            snap_first;
  logic [31:0]            snap_stamp;
  logic [31:0]            snap_source;
  logic [31:0]            snap_ext;
  logic [7:0]             snap_byte;

  logic accept;
  logic res_load;

  assign res_load = snap_valid && (!out_valid || out_ready);
  assign in_ready = !snap_valid || res_load;
  assign accept   = in_valid && in_ready;

  always_comb begin
    first_word_next      = first_word;
    stamp_word_next      = stamp_word;
    source_word_next     = source_word;
    ext_header_word_next = ext_header_word;
    ext_start = LENGTH_BITS'(FIXED_HDR) + LENGTH_BITS'({first_word[27:24], 2'b00});
    in_ext    = (byte_count >= ext_start) &&
                (byte_count < ext_start + LENGTH_BITS'(WORD_BYTES));
    if (byte_count < LENGTH_BITS'(4)) begin
      first_word_next = {first_word[23:0], packet_byte};
    end else if (byte_count < LENGTH_BITS'(8)) begin
      stamp_word_next = {stamp_word[23:0], packet_byte};
    end else if (byte_count < LENGTH_BITS'(FIXED_HDR)) begin
      source_word_next = {source_word[23:0], packet_byte};
    end else if (in_ext) begin
      ext_header_word_next = {ext_header_word[23:0], packet_byte};
    end
    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + LENGTH_BITS'(1)
                                                : byte_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      first_word      <= '0;
      stamp_word      <= '0;
      source_word     <= '0;
      ext_header_word <= '0;
    end else if (accept) begin
      if (last_byte) begin
        byte_count      <= '0;
        first_word      <= '0;
        stamp_word      <= '0;
        source_word     <= '0;
        ext_header_word <= '0;
      end else begin
        byte_count      <= byte_count_next;
        first_word      <= first_word_next;
        stamp_word      <= stamp_word_next;
        source_word     <= source_word_next;
        ext_header_word <= ext_header_word_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (accept && last_byte) begin
      snap_valid <= 1'b1;
    end else if (res_load) begin
      snap_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      snap_count  <= byte_count_next;
      snap_first  <= first_word_next;
      snap_stamp  <= stamp_word_next;
      snap_source <= source_word_next;
      snap_ext    <= ext_header_word_next;
      snap_byte   <= packet_byte;
    end
  end

  // length arithmetic on the snapshot
  logic [1:0]  ver;
  logic        pad_flag;
  logic        ext_flag;
  logic [3:0]  cc;
  logic [6:0]  hlen;
  logic [6:0]  need;
  logic [19:0] n_wide;
  logic [19:0] avail;
  logic [19:0] elen4;
  logic [19:0] avail_e;
  logic [19:0] avail_p;
  logic [19:0] off;
  logic        short_fixed;
  logic        short_hdr;
  logic        ext_over;
  logic        pad_over;
  logic [2:0]  status_next;

  always_comb begin
    ver         = snap_first[31:30];
    pad_flag    = snap_first[29];
    ext_flag    = snap_first[28];
    cc          = snap_first[27:24];
    hlen        = 7'(FIXED_HDR) + {1'b0, cc, 2'b00};
    need        = hlen + {4'd0, ext_flag, 2'b00} + {6'd0, pad_flag};
    n_wide      = 20'(snap_count);
    short_fixed = snap_count < LENGTH_BITS'(FIXED_HDR);
    short_hdr   = n_wide < 20'(need);
    avail       = n_wide - 20'(hlen);
    elen4       = {2'b00, snap_ext[15:0], 2'b00} + 20'(WORD_BYTES);
    ext_over    = ext_flag && (elen4 > avail);
    avail_e     = ext_flag ? avail - elen4 : avail;
    off         = 20'(hlen) + (ext_flag ? elen4 : 20'd0);
    // with padding the final byte holds the pad count
    pad_over    = pad_flag && (avail_e < 20'(snap_byte));
    avail_p     = pad_flag ? avail_e - 20'(snap_byte) : avail_e;

    if (short_fixed) begin
      status_next = ST_SHORT;
    end else if (ver != HDR_VER_EXPECTED) begin
      status_next = ST_BAD_VER;
    end else if (short_hdr) begin
      status_next = ST_SHORT;
    end else if (ext_over) begin
      status_next = ST_EXT_OVER;
    end else if (pad_over) begin
      status_next = ST_PAD_OVER;
    end else begin
      status_next = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status <= status_next;
      if (short_fixed) begin
        marker        <= 1'b0;
        payload_kind  <= '0;
        sequence_res  <= '0;
        time_stamp    <= '0;
        source_id     <= '0;
        contrib_count <= '0;
        has_extension <= 1'b0;
      end else begin
        marker        <= snap_first[23];
        payload_kind  <= snap_first[22:16];
        sequence_res  <= snap_first[15:0];
        time_stamp    <= snap_stamp;
        source_id     <= snap_source;
        contrib_count <= cc;
        has_extension <= ext_flag;
      end
      // extension reported once the header itself is complete and valid
      if (!short_fixed && ver == HDR_VER_EXPECTED && !short_hdr && ext_flag) begin
        ext_profile <= snap_ext[31:16];
        ext_words   <= snap_ext[15:0];
      end else begin
        ext_profile <= '0;
        ext_words   <= '0;
      end
      if (status_next == ST_OK) begin
        payload_offset <= (off > 20'(OUT_LEN_MAX)) ? OUT_LEN_MAX : off[OUT_LEN_BITS-1:0];
        payload_length <= (avail_p > 20'(OUT_LEN_MAX)) ? OUT_LEN_MAX
                                                       : avail_p[OUT_LEN_BITS-1:0];
      end else begin
        payload_offset <= '0;
        payload_length <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/rhp_checker.sv
// ---------------------------------------------------------------------------
// rhp_checker
// port level checks for the rtp header parser, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

module rhp_checker
  import rhp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic        has_extension,
  input wire logic [15:0] ext_profile,
  input wire logic [15:0] ext_words,
  input wire logic [15:0] payload_offset,
  input wire logic [15:0] payload_length
);

  // a held result keeps its status
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_SHORT || status == ST_BAD_VER ||
                   status == ST_EXT_OVER || status == ST_PAD_OVER))
    else $error("status outside its codes");

  // payload placement only on a clean packet
  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> payload_offset == 16'd0 && payload_length == 16'd0)
    else $error("payload fields set on an error result");

  a_ext_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_extension |-> ext_profile == 16'd0 && ext_words == 16'd0)
    else $error("extension fields set without the extension flag");

  // a clean packet starts its payload past the fixed header
  a_offset_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> payload_offset >= 16'(FIXED_HDR))
    else $error("payload offset inside the fixed header");

endmodule

bind rtp_header_parser rhp_checker u_rhp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .has_extension  (has_extension),
  .ext_profile    (ext_profile),
  .ext_words      (ext_words),
  .payload_offset (payload_offset),
  .payload_length (payload_length)
);

`default_nettype wire

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the rtp header parser: packets go in one byte per
// item, and each per-packet result is compared field by field with a
// behavioural parser kept inside the bench. a table of hand-picked packets
// (short packets, bad versions, extension and padding overruns, packets past
// the length counter limit) comes first, then random packets, mostly well
// formed, with random gaps on the input side and random stalls on the output
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rhp_pkg::*;

  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int RANDOM_BYTES  = 600;
  localparam int RANDOM_FRAMES = 40;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_FRAME    = 70000;

  typedef struct {
    logic [2:0]  status;
    logic        marker;
    logic [6:0]  kind;
    logic [15:0] seq;
    logic [31:0] stamp;
    logic [31:0] source;
    logic [3:0]  cc;
    logic        ext;
    logic [15:0] profile;
    logic [15:0] words;
    logic [15:0] offset;
    logic [15:0] length;
  } rtp_result_t;

  typedef struct {
    logic [31:0] hdr;
    logic [31:0] stamp;
    logic [31:0] source;
    logic [31:0] ext_hdr;
    int          total;
    logic [7:0]  tail;
    bit          typed;
    logic [2:0]  want_status;
    logic [15:0] want_offset;
    logic [15:0] want_length;
  } frame_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  packet_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic        marker;
  logic [6:0]  payload_kind;
  logic [15:0] sequence_res;
  logic [31:0] time_stamp;
  logic [31:0] source_id;
  logic [3:0]  contrib_count;
  logic        has_extension;
  logic [15:0] ext_profile;
  logic [15:0] ext_words;
  logic [OUT_LEN_BITS-1:0] payload_offset;
  logic [OUT_LEN_BITS-1:0] payload_length;

  // parser state mirrored in the bench
  logic [LENGTH_BITS-1:0] seen_bytes = '0;
  logic [31:0] hdr_acc = '0;
  logic [31:0] stamp_acc = '0;
  logic [31:0] source_acc = '0;
  logic [31:0] ext_acc = '0;

  rtp_result_t results_due[$];

  bit          typed_pending = 1'b0;
  logic [2:0]  typed_status;
  logic [15:0] typed_offset;
  logic [15:0] typed_length;
  bit          frame_calm = 1'b0;

  int bytes_sent = 0;
  int frames_done = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int status_tally[8];

  rtp_header_parser u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .packet_byte    (packet_byte),
    .last_byte      (last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .marker         (marker),
    .payload_kind   (payload_kind),
    .sequence_res   (sequence_res),
    .time_stamp     (time_stamp),
    .source_id      (source_id),
    .contrib_count  (contrib_count),
    .has_extension  (has_extension),
    .ext_profile    (ext_profile),
    .ext_words      (ext_words),
    .payload_offset (payload_offset),
    .payload_length (payload_length)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] rtp_word(input logic [1:0] ver, input bit p, input bit x,
                                           input logic [3:0] cc, input bit m,
                                           input logic [6:0] pt, input logic [15:0] seq);
    return {ver, p, x, cc, m, pt, seq};
  endfunction

  // mostly short gaps, now and then a long one, none in a calm stretch
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one accepted byte through the bench's own parser
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    int pos, start, n, hlen, off, avail, elen;
    rtp_result_t r;
    pos = int'(seen_bytes);
    if (pos < WORD_BYTES) hdr_acc = {hdr_acc[23:0], b};
    else if (pos < 2 * WORD_BYTES) stamp_acc = {stamp_acc[23:0], b};
    else if (pos < FIXED_HDR) source_acc = {source_acc[23:0], b};
    else begin
      // csrc words are skipped, the extension header follows them
      start = FIXED_HDR + WORD_BYTES * int'(hdr_acc[27:24]);
      if (pos >= start && pos < start + WORD_BYTES) ext_acc = {ext_acc[23:0], b};
    end
    if (seen_bytes != COUNT_MAX) seen_bytes = seen_bytes + 1'b1;
    if (!fin) return;

    r = '{default: '0};
    n = int'(seen_bytes);
    if (n < FIXED_HDR) begin
      r.status = ST_SHORT;
    end else begin
      hlen = FIXED_HDR + WORD_BYTES * int'(hdr_acc[27:24]);
      r.marker = hdr_acc[23];
      r.kind   = hdr_acc[22:16];
      r.seq    = hdr_acc[15:0];
      r.stamp  = stamp_acc;
      r.source = source_acc;
      r.cc     = hdr_acc[27:24];
      r.ext    = hdr_acc[28];
      r.status = ST_OK;
      if (hdr_acc[31:30] != HDR_VER_EXPECTED) begin
        r.status = ST_BAD_VER;
      end else if (n < hlen + WORD_BYTES * int'(hdr_acc[28]) + int'(hdr_acc[29])) begin
        r.status = ST_SHORT;
      end else begin
        off = hlen;
        avail = n - hlen;
        if (hdr_acc[28]) begin
          r.profile = ext_acc[31:16];
          r.words = ext_acc[15:0];
          elen = WORD_BYTES * int'(ext_acc[15:0]);
          if (elen + WORD_BYTES > avail) begin
            r.status = ST_EXT_OVER;
          end else begin
            avail -= elen + WORD_BYTES;
            off += elen + WORD_BYTES;
          end
        end
        // with padding set the final byte is the pad count
        if (r.status == ST_OK && hdr_acc[29]) begin
          if (avail < int'(b)) r.status = ST_PAD_OVER;
          else avail -= int'(b);
        end
        if (r.status == ST_OK) begin
          r.offset = (off > int'(OUT_LEN_MAX)) ? OUT_LEN_MAX : 16'(off);
          r.length = (avail > int'(OUT_LEN_MAX)) ? OUT_LEN_MAX : 16'(avail);
        end
      end
    end
    if (typed_pending) begin
      r.status = typed_status;
      r.offset = typed_offset;
      r.length = typed_length;
      typed_pending = 1'b0;
    end
    results_due.push_back(r);
    frames_done++;
    seen_bytes = '0;
    hdr_acc = '0;
    stamp_acc = '0;
    source_acc = '0;
    ext_acc = '0;
  endtask

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = pick_gap(frame_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    packet_byte <= b;
    last_byte <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_byte(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input frame_row_t row);
    int hlen;
    logic [7:0] v;
    hlen = FIXED_HDR + WORD_BYTES * int'(row.hdr[27:24]);
    typed_pending = row.typed;
    typed_status = row.want_status;
    typed_offset = row.want_offset;
    typed_length = row.want_length;
    frame_calm = (row.total > 1000) || ($urandom_range(0, 5) == 0);
    for (int i = 0; i < row.total; i++) begin
      if (i < WORD_BYTES) v = row.hdr[31 - 8 * i -: 8];
      else if (i < 2 * WORD_BYTES) v = row.stamp[31 - 8 * (i - 4) -: 8];
      else if (i < FIXED_HDR) v = row.source[31 - 8 * (i - 8) -: 8];
      else if (i >= hlen && i < hlen + WORD_BYTES) v = row.ext_hdr[31 - 8 * (i - hlen) -: 8];
      else v = 8'($urandom());
      if (i == row.total - 1) v = row.tail;
      send_byte(v, i == row.total - 1);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    rtp_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result item with no packet pending");
        mismatches++;
      end else begin
        want = results_due.pop_front();
        check_field("status", 32'(want.status), 32'(status));
        check_field("marker", 32'(want.marker), 32'(marker));
        check_field("payload_kind", 32'(want.kind), 32'(payload_kind));
        check_field("sequence_res", 32'(want.seq), 32'(sequence_res));
        check_field("time_stamp", want.stamp, time_stamp);
        check_field("source_id", want.source, source_id);
        check_field("contrib_count", 32'(want.cc), 32'(contrib_count));
        check_field("has_extension", 32'(want.ext), 32'(has_extension));
        check_field("ext_profile", 32'(want.profile), 32'(ext_profile));
        check_field("ext_words", 32'(want.words), 32'(ext_words));
        check_field("payload_offset", 32'(want.offset), 32'(payload_offset));
        check_field("payload_length", 32'(want.length), 32'(payload_length));
        status_tally[want.status]++;
      end
    end
  end

  // output back-pressure: ready stretches broken by stalls
  initial begin : sink_stall
    int unsigned stall;
    bit calm;
    forever begin
      out_ready <= 1'b1;
      calm = ($urandom_range(0, 7) == 0);
      repeat (1 + $urandom_range(0, calm ? 200 : 6)) @(negedge clk);
      stall = pick_gap(calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               results_due.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    frame_row_t rows[$];
    frame_row_t row;
    logic [31:0] rnd;
    logic [3:0] cc;
    logic [1:0] ver;
    bit xb, pb;
    int kind, pay, words, rand_start;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // hdr, timestamp, ssrc, extension word, bytes, final byte,
    // typed, status, offset, length
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 0, 4'd0, 0, 7'd0, 16'd0),
      32'h0, 32'h0, 32'h0, 1, 8'hFF, 1'b1, ST_SHORT, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 0, 4'd0, 1, 7'h7F, 16'hFFFF),
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 11, 8'h00, 1'b1, ST_SHORT, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 0, 4'd0, 0, 7'd0, 16'd0),
      32'h0, 32'h0, 32'h0, 12, 8'h00, 1'b1, ST_OK, 16'd12, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(2'd0, 0, 0, 4'd0, 0, 7'd96, 16'h1234),
      $urandom(), $urandom(), 32'h0, 20, 8'h5A, 1'b1, ST_BAD_VER, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
      32'hFFFF_FFFF, 12, 8'hFF, 1'b1, ST_BAD_VER, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 0, 4'd15, 0, 7'd0, 16'd7),
      $urandom(), $urandom(), 32'h0, 70, 8'h11, 1'b1, ST_SHORT, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 0, 4'd15, 1, 7'h7F, 16'hFFFF),
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 82, 8'hFF, 1'b1, ST_OK, 16'd72, 16'd10});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 1, 4'd0, 0, 7'd8, 16'd1),
      $urandom(), $urandom(), 32'hABCD_0000, 15, 8'h33, 1'b1, ST_SHORT, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 1, 4'd0, 0, 7'd8, 16'd2),
      $urandom(), $urandom(), 32'hABCD_0000, 16, 8'h00, 1'b1, ST_OK, 16'd16, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 1, 4'd0, 0, 7'd9, 16'd3),
      $urandom(), $urandom(), 32'h0001_0002, 23, 8'h44, 1'b1, ST_EXT_OVER, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 1, 4'd0, 0, 7'd9, 16'd4),
      $urandom(), $urandom(), 32'hFFFF_FFFF, 40, 8'h55, 1'b1, ST_EXT_OVER, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 1, 4'd0, 0, 7'd10, 16'd5),
      $urandom(), $urandom(), 32'h5555_0001, 30, 8'hAA, 1'b1, ST_OK, 16'd20, 16'd10});
    // padding: the final byte is the pad count
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 1, 0, 4'd0, 0, 7'd11, 16'd6),
      $urandom(), $urandom(), 32'h0, 12, 8'h00, 1'b1, ST_SHORT, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 1, 0, 4'd0, 0, 7'd11, 16'd7),
      $urandom(), $urandom(), 32'h0, 13, 8'h01, 1'b1, ST_OK, 16'd12, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 1, 0, 4'd0, 0, 7'd12, 16'd8),
      $urandom(), $urandom(), 32'h0, 20, 8'h09, 1'b1, ST_PAD_OVER, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 1, 0, 4'd0, 0, 7'd12, 16'd9),
      $urandom(), $urandom(), 32'h0, 20, 8'h08, 1'b1, ST_OK, 16'd12, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 1, 1, 4'd2, 0, 7'd13, 16'd10),
      $urandom(), $urandom(), 32'h00FF_0001, 40, 8'h03, 1'b1, ST_OK, 16'd28, 16'd9});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 1, 0, 4'd0, 1, 7'd14, 16'd11),
      $urandom(), $urandom(), 32'h0, 300, 8'hFF, 1'b1, ST_OK, 16'd12, 16'd33});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 1, 1, 4'd0, 0, 7'd15, 16'd12),
      $urandom(), $urandom(), 32'h0000_000A, 30, 8'h00, 1'b1, ST_EXT_OVER, 16'd0, 16'd0});
    rows.push_back(frame_row_t'{rtp_word(2'd1, 1, 1, 4'd0, 0, 7'd16, 16'd13),
      $urandom(), $urandom(), 32'h0, 12, 8'h02, 1'b1, ST_BAD_VER, 16'd0, 16'd0});
    // past the counter limit the length stops at its saturated value
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 0, 0, 4'd0, 0, 7'd17, 16'd14),
      $urandom(), $urandom(), 32'h0, LONG_FRAME, 8'($urandom()), 1'b1, ST_OK,
      16'd12, 16'd65523});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 1, 0, 4'd0, 0, 7'd18, 16'd15),
      $urandom(), $urandom(), 32'h0, LONG_FRAME, 8'hFF, 1'b1, ST_OK,
      16'd12, 16'd65268});
    rows.push_back(frame_row_t'{rtp_word(HDR_VER_EXPECTED, 1, 1, 4'd3, 1, 7'($urandom()),
      16'($urandom())), $urandom(), $urandom(), 32'h1234_0002, 50, 8'h04, 1'b0,
      ST_OK, 16'd0, 16'd0});

    foreach (rows[i]) send_frame(rows[i]);

    // random packets: most well formed, the rest broken in one way or another
    rand_start = bytes_sent;
    while (bytes_sent - rand_start < RANDOM_BYTES || frames_done < rows.size() + RANDOM_FRAMES)
    begin
      kind = $urandom_range(0, 99);
      rnd = $urandom();
      cc = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
      xb = 1'($urandom_range(0, 1));
      pb = 1'($urandom_range(0, 1));
      words = $urandom_range(0, 3);
      pay = $urandom_range(0, 12);
      ver = HDR_VER_EXPECTED;
      if (kind >= 75 && kind < 81) begin
        ver = 2'($urandom_range(0, 2));
        if (ver == HDR_VER_EXPECTED) ver = 2'd3;
      end
      if (kind >= 89 && kind < 95) xb = 1'b1;
      if (kind >= 95) pb = 1'b1;
      if (pb && pay == 0) pay = 1;
      row = '{default: '0};
      row.hdr = {ver, pb, xb, cc, rnd[23:0]};
      row.stamp = $urandom();
      row.source = $urandom();
      row.ext_hdr = {16'($urandom()), 16'(words)};
      row.total = FIXED_HDR + WORD_BYTES * int'(cc) + (xb ? WORD_BYTES * (words + 1) : 0) + pay;
      row.tail = pb ? 8'($urandom_range(0, pay)) : 8'($urandom());
      if (kind >= 81 && kind < 89) row.total = $urandom_range(1, row.total);
      else if (kind >= 89 && kind < 95) row.ext_hdr[15:0] = 16'($urandom_range(words + 1, 65535));
      else if (kind >= 95) row.tail = 8'($urandom_range(pay + 1, 255));
      send_frame(row);
    end
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d packets from %0d bytes, two of them past the length counter limit",
             frames_done, bytes_sent);
    $display("by status: ok %0d, short %0d, bad version %0d, ext overrun %0d, pad overrun %0d",
             status_tally[ST_OK], status_tally[ST_SHORT], status_tally[ST_BAD_VER],
             status_tally[ST_EXT_OVER], status_tally[ST_PAD_OVER]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: rtp_header_parser.f
src/rhp_pkg.sv
src/rtp_header_parser.sv
src/rhp_checker.sv
verif/tb_top.sv
